>>> src/tafs_pkg.sv
// Package for the triangle angle block: shared widths, item types and the CORDIC angle table.
// Depends on nothing. Every other file of the block imports it.
`timescale 1ns / 1ps

package tafs_pkg;

    localparam int SIDE_W    = 16;  // width of one side field
    localparam int ANG_W     = 15;  // width of one angle field
    localparam int PROD_W    = 2 * SIDE_W;
    localparam int WIDE_W    = PROD_W + 1;   // sums of squares and twice a product
    localparam int DIV_N     = 18;  // quotient bits of the cosine ratio
    localparam int SQRT_N    = 17;  // root bits of the sine term
    localparam int CORDIC_N  = 18;  // vectoring iterations
    localparam int LANE_LAT  = DIV_N + 1 + SQRT_N + CORDIC_N + 1;

    // atan(2^-i) in Q16 hundredths of a degree, rounded
    localparam logic signed [31:0] ATAN_TAB [CORDIC_N] = '{
        32'sd294912000, 32'sd174096719, 32'sd91987925, 32'sd46694507,
        32'sd23437865,  32'sd11730358,  32'sd5866609,  32'sd2933484,
        32'sd1466764,   32'sd733385,    32'sd366693,   32'sd183346,
        32'sd91673,     32'sd45837,     32'sd22918,    32'sd11459,
        32'sd5730,      32'sd2865
    };

    localparam logic signed [32:0] QUARTER_Q16 = 33'sd589824000;
    localparam logic signed [32:0] HALF_Q16    = 33'sd1179648000;

    typedef struct packed {
        logic [SIDE_W-1:0] side_a;
        logic [SIDE_W-1:0] side_b;
        logic [SIDE_W-1:0] side_c;
    } t_in_item;

    typedef struct packed {
        logic [ANG_W-1:0] angle_a;
        logic [ANG_W-1:0] angle_b;
        logic [ANG_W-1:0] angle_c;
        logic             invalid;
    } t_out_item;

    // One angle's worth of classified work: |numerator|, denominator and sign
    typedef struct packed {
        logic              neg;
        logic [WIDE_W-1:0] mag;
        logic [WIDE_W-1:0] den;
    } t_lane_in;

    typedef struct packed {
        t_lane_in [2:0] lane;
        logic           bad;
    } t_task;

endpackage

>>> src/tafs_if.sv
// Handshake interfaces for the input triangles and the result angles.
// Depends on tafs_pkg for the payload types.
`timescale 1ns / 1ps

interface tafs_in_if;
    import tafs_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tafs_out_if;
    import tafs_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/tafs_front.sv
// Front end: masks the sides, forms squares and products, and classifies each angle.
// Depends on tafs_pkg and tafs_if.
`timescale 1ns / 1ps

module tafs_front #(
    parameter int SIDE_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    tafs_in_if.sink          i_in,
    output logic             o_valid,
    output tafs_pkg::t_task  o_task,
    input  logic             i_ready
);
    import tafs_pkg::*;

    localparam int SB_EFF = (SIDE_BITS < SIDE_W) ? SIDE_BITS : SIDE_W;
    localparam logic [SIDE_W-1:0] MASK = SIDE_W'((33'd1 << SB_EFF) - 33'd1);

    logic              en;
    logic [SIDE_W-1:0] a, b, c;
    logic              r_v1, r_v2, r_v3;
    logic [PROD_W-1:0] r_sq [3];
    logic [PROD_W-1:0] r_pr [3];
    logic              r_zero1, r_zero2;
    logic [WIDE_W-1:0] r_pos [3];
    logic [WIDE_W-1:0] r_den [3];
    logic [WIDE_W-1:0] r_opp [3];
    t_task             r_task;
    t_task             n_task;

    // The whole front moves together; it holds while the queue is full
    assign en        = !r_v3 || i_ready;
    assign i_in.ready = en;
    assign a = i_in.data.side_a & MASK;
    assign b = i_in.data.side_b & MASK;
    assign c = i_in.data.side_c & MASK;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_in.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Stage one: squares of the sides and the three pairwise products.
    // Products are indexed by the angle they serve: bc for A, ac for B, ab for C.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq[0] <= a * a;
            r_sq[1] <= b * b;
            r_sq[2] <= c * c;
            r_pr[0] <= b * c;
            r_pr[1] <= a * c;
            r_pr[2] <= a * b;
            r_zero1 <= (a == '0) || (b == '0) || (c == '0);
        end
    end

    // Stage two: sum of adjacent squares, twice the adjacent product
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pos[0] <= WIDE_W'(r_sq[1]) + WIDE_W'(r_sq[2]);
            r_pos[1] <= WIDE_W'(r_sq[0]) + WIDE_W'(r_sq[2]);
            r_pos[2] <= WIDE_W'(r_sq[0]) + WIDE_W'(r_sq[1]);
            for (int k = 0; k < 3; k++) begin
                r_den[k] <= {r_pr[k], 1'b0};
                r_opp[k] <= WIDE_W'(r_sq[k]);
            end
            r_zero2 <= r_zero1;
        end
    end

    // Stage three: sign and magnitude of the numerator, range check against the denominator
    always_comb begin
        n_task.bad = r_zero2;
        for (int k = 0; k < 3; k++) begin
            n_task.lane[k].neg = r_pos[k] < r_opp[k];
            n_task.lane[k].mag = n_task.lane[k].neg ? r_opp[k] - r_pos[k]
                                                    : r_pos[k] - r_opp[k];
            n_task.lane[k].den = r_den[k];
            if (n_task.lane[k].mag > r_den[k]) begin
                n_task.bad = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_task <= n_task;
        end
    end

    assign o_valid = r_v3;
    assign o_task  = r_task;

endmodule

>>> src/tafs_queue.sv
// Two-entry queue that decouples the front end from the angle pipeline.
// Depends on tafs_pkg.
`timescale 1ns / 1ps

module tafs_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  tafs_pkg::t_task i_task,
    output logic            o_ready,
    output logic            o_valid,
    output tafs_pkg::t_task o_task,
    input  logic            i_ready
);
    import tafs_pkg::*;

    t_task      r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_task  = r_mem[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_task;
        end
    end

endmodule

>>> src/tafs_lane.sv
// One angle: ratio division, sine term square root, CORDIC vectoring and rounding.
// Depends on tafs_pkg.
`timescale 1ns / 1ps

module tafs_lane (
    input  logic               i_clk,
    input  logic               i_en,
    input  tafs_pkg::t_lane_in i_lane,
    output logic [tafs_pkg::ANG_W-1:0] o_angle
);
    import tafs_pkg::*;

    localparam int NUM_W = WIDE_W + 19;  // numerator shifted by 17 plus rounding term
    localparam int D2_W  = WIDE_W + 1;
    localparam int SQ_W  = 34;
    localparam int CR_W  = 34;

    // Division stages: one quotient bit each, most significant first
    logic [NUM_W-1:0] r_rem [DIV_N];
    logic [D2_W-1:0]  r_d2  [DIV_N];
    logic [DIV_N-1:0] r_q   [DIV_N];
    logic             r_ng  [DIV_N];

    for (genvar j = 0; j < DIV_N; j++) begin : g_div
        localparam int K = DIV_N - 1 - j;
        logic [NUM_W-1:0] w_rem;
        logic [D2_W-1:0]  w_d2;
        logic [DIV_N-1:0] w_q;
        logic             w_ng;
        logic [NUM_W-1:0] t;
        if (j == 0) begin : g_first
            assign w_rem = (NUM_W'(i_lane.mag) << 17) + NUM_W'(i_lane.den);
            assign w_d2  = {i_lane.den, 1'b0};
            assign w_q   = '0;
            assign w_ng  = i_lane.neg;
        end else begin : g_next
            assign w_rem = r_rem[j-1];
            assign w_d2  = r_d2[j-1];
            assign w_q   = r_q[j-1];
            assign w_ng  = r_ng[j-1];
        end
        assign t = NUM_W'(w_d2) << K;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (t <= w_rem) begin
                    r_rem[j] <= w_rem - t;
                    r_q[j]   <= w_q | (DIV_N'(1) << K);
                end else begin
                    r_rem[j] <= w_rem;
                    r_q[j]   <= w_q;
                end
                r_d2[j] <= w_d2;
                r_ng[j] <= w_ng;
            end
        end
    end

    // Square of the ratio
    logic [DIV_N-1:0]   r_r;
    logic [2*DIV_N-1:0] r_rr;
    logic               r_sng;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r   <= r_q[DIV_N-1];
            r_rr  <= r_q[DIV_N-1] * r_q[DIV_N-1];
            r_sng <= r_ng[DIV_N-1];
        end
    end

    // Square root stages of 2^32 - ratio^2, one root bit each
    logic [SQ_W-1:0]  r_v   [SQRT_N];
    logic [SQ_W-1:0]  r_res [SQRT_N];
    logic [DIV_N-1:0] r_sr  [SQRT_N];
    logic             r_sq  [SQRT_N];

    for (genvar j = 0; j < SQRT_N; j++) begin : g_sqrt
        logic [SQ_W-1:0]  w_v, w_res, bitv, trial;
        logic [DIV_N-1:0] w_r;
        logic             w_ng;
        if (j == 0) begin : g_first
            logic [2*DIV_N-1:0] diff;
            assign diff  = (36'd1 << 32) - r_rr;
            assign w_v   = SQ_W'(diff[32:0]);
            assign w_res = '0;
            assign w_r   = r_r;
            assign w_ng  = r_sng;
        end else begin : g_next
            assign w_v   = r_v[j-1];
            assign w_res = r_res[j-1];
            assign w_r   = r_sr[j-1];
            assign w_ng  = r_sq[j-1];
        end
        assign bitv  = SQ_W'(1) << (2 * (SQRT_N - 1 - j));
        assign trial = w_res + bitv;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_v >= trial) begin
                    r_v[j]   <= w_v - trial;
                    r_res[j] <= (w_res >> 1) + bitv;
                end else begin
                    r_v[j]   <= w_v;
                    r_res[j] <= w_res >> 1;
                end
                r_sr[j] <= w_r;
                r_sq[j] <= w_ng;
            end
        end
    end

    // CORDIC vectoring stages on (ratio, sine term)
    logic signed [CR_W-1:0] r_x [CORDIC_N];
    logic signed [CR_W-1:0] r_y [CORDIC_N];
    logic signed [31:0]     r_z [CORDIC_N];
    logic                   r_cn [CORDIC_N];

    for (genvar i = 0; i < CORDIC_N; i++) begin : g_cordic
        logic signed [CR_W-1:0] w_x, w_y, xs, ys;
        logic signed [31:0]     w_z;
        logic                   w_ng;
        if (i == 0) begin : g_first
            assign w_x  = signed'(CR_W'(r_sr[SQRT_N-1]) << 14);
            assign w_y  = signed'(CR_W'(r_res[SQRT_N-1][SQRT_N-1:0]) << 14);
            assign w_z  = '0;
            assign w_ng = r_sq[SQRT_N-1];
        end else begin : g_next
            assign w_x  = r_x[i-1];
            assign w_y  = r_y[i-1];
            assign w_z  = r_z[i-1];
            assign w_ng = r_cn[i-1];
        end
        assign xs = w_x >>> i;
        assign ys = w_y >>> i;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_y > 0) begin
                    r_x[i] <= w_x + ys;
                    r_y[i] <= w_y - xs;
                    r_z[i] <= w_z + ATAN_TAB[i];
                end else begin
                    r_x[i] <= w_x - ys;
                    r_y[i] <= w_y + xs;
                    r_z[i] <= w_z - ATAN_TAB[i];
                end
                r_cn[i] <= w_ng;
            end
        end
    end

    // Clamp to a quarter turn, fold obtuse angles, round to hundredths
    logic signed [32:0] zc, zf, zr;
    logic [ANG_W-1:0]   r_angle;

    always_comb begin
        zc = 33'(r_z[CORDIC_N-1]);
        if (zc < 0) zc = '0;
        if (zc > QUARTER_Q16) zc = QUARTER_Q16;
        zf = r_cn[CORDIC_N-1] ? HALF_Q16 - zc : zc;
        zr = zf + 33'sd32768;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_angle <= zr[16 +: ANG_W];
        end
    end

    assign o_angle = r_angle;

endmodule

>>> src/tafs_back.sv
// Back end: three angle lanes in lock step with a valid and invalid-flag chain.
// Depends on tafs_pkg, tafs_if and tafs_lane.
`timescale 1ns / 1ps

module tafs_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  tafs_pkg::t_task i_task,
    output logic            o_ready,
    tafs_out_if.source      o_out
);
    import tafs_pkg::*;

    logic                en;
    logic [LANE_LAT-1:0] r_v;
    logic [LANE_LAT-1:0] r_bad;
    logic [ANG_W-1:0]    ang [3];
    logic                bad;

    // The pipeline advances unless a finished beat is waiting at the output
    assign en      = !r_v[LANE_LAT-1] || o_out.ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[LANE_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_bad <= {r_bad[LANE_LAT-2:0], i_task.bad};
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_lane
        tafs_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_lane  (i_task.lane[k]),
            .o_angle (ang[k])
        );
    end

    // A rejected triangle reports all angles as zero
    assign bad = r_bad[LANE_LAT-1];
    assign o_out.valid        = r_v[LANE_LAT-1];
    assign o_out.data.angle_a = bad ? '0 : ang[0];
    assign o_out.data.angle_b = bad ? '0 : ang[1];
    assign o_out.data.angle_c = bad ? '0 : ang[2];
    assign o_out.data.invalid = bad;

endmodule

>>> src/triangle_angles_from_sides.sv
// Triangle angles from three sides by the law of cosines, one triangle per beat.
// Each angle has its own divider, root and CORDIC lane behind the front end and the queue.
// Throughput: one triangle per clock while the output accepts results.
// Reset (synchronous, active low) empties the pipeline and the queue; no clearing pass.
// Depends on tafs_pkg, tafs_if, tafs_front, tafs_queue and tafs_back.
`timescale 1ns / 1ps

module triangle_angles_from_sides #(
    parameter int SIDE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tafs_in_if.sink     i_in,
    tafs_out_if.source  o_out
);
    import tafs_pkg::*;

    logic  f_valid, f_ready;
    t_task f_task;
    logic  q_valid, q_ready;
    t_task q_task;

    tafs_front #(
        .SIDE_BITS (SIDE_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (f_valid),
        .o_task  (f_task),
        .i_ready (f_ready)
    );

    tafs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .i_task  (f_task),
        .o_ready (f_ready),
        .o_valid (q_valid),
        .o_task  (q_task),
        .i_ready (q_ready)
    );

    tafs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_task  (q_task),
        .o_ready (q_ready),
        .o_out   (o_out)
    );

endmodule

>>> test/tb_top.sv
// Testbench for triangle_angles_from_sides: drives triangles through the input channel
// and checks every result beat against a predictor of the law-of-cosines CORDIC datapath.
// Depends on tafs_pkg, tafs_if and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
    import tafs_pkg::*;

    localparam int LATENCY    = 59;
    localparam int WDOG_LIMIT = 20000;

    logic i_clk;
    logic i_rst_n;

    tafs_in_if  in_ch ();
    tafs_out_if out_ch ();

    triangle_angles_from_sides #(.SIDE_BITS(16)) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    t_out_item expected_angles[$];
    int        n_errors;
    int        n_sent;
    int        n_checked;
    int        n_invalid;
    int        idle_cycles;
    bit        hold_sink;
    bit        timed_out;

    // Clock generation.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Integer square root by the bit-pair method.
    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // One angle opposite side opp, in hundredths of a degree; sets bad for a non-triangle.
    function automatic logic [ANG_W-1:0] angle_opposite(logic [63:0] opp, logic [63:0] adj1,
                                                        logic [63:0] adj2, ref bit bad);
        logic [127:0]  pos;
        logic [127:0]  negsq;
        logic [127:0]  den;
        logic [127:0]  mag;
        longint        r;
        longint        x;
        longint        y;
        longint        z;
        longint        xs;
        longint        ys;
        bit            negative;
        pos      = adj1 * adj1 + adj2 * adj2;
        negsq    = opp * opp;
        den      = (adj1 * adj2) << 1;
        negative = pos < negsq;
        mag      = negative ? negsq - pos : pos - negsq;
        if (mag > den) begin
            bad = 1'b1;
            return '0;
        end
        // Rounded Q1.16 magnitude of the ratio, half away from zero.
        r = longint'(((mag << 17) + den) / (den << 1));
        x = r <<< 14;
        y = longint'(isqrt((64'd1 << 32) - 64'(r * r))) <<< 14;
        z = 0;
        for (int i = 0; i < CORDIC_N; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(ATAN_TAB[i]);
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(ATAN_TAB[i]);
            end
        end
        if (z < 0) z = 0;
        if (z > longint'(QUARTER_Q16)) z = longint'(QUARTER_Q16);
        if (negative) z = longint'(HALF_Q16) - z;
        return ANG_W'((z + 32768) >>> 16);
    endfunction

    function automatic t_out_item predict_angles(t_in_item tri_in);
        t_out_item   res;
        bit          bad;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        a   = 64'(tri_in.side_a);
        b   = 64'(tri_in.side_b);
        c   = 64'(tri_in.side_c);
        bad = 1'b0;
        res = '0;
        if (a == 0 || b == 0 || c == 0) begin
            bad = 1'b1;
        end else begin
            res.angle_a = angle_opposite(a, b, c, bad);
            res.angle_b = angle_opposite(b, a, c, bad);
            res.angle_c = angle_opposite(c, a, b, bad);
        end
        if (bad) res = '0;
        res.invalid = bad;
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("Mismatch on result %0d: %s is %0d, expected %0d", n_checked, what, got, want);
        n_errors++;
    endtask

    // Sends one triangle after a random gap and records its expected angles.
    // Valid stays high after the beat so that back-to-back sends keep it asserted.
    task automatic send_triangle(logic [15:0] a, logic [15:0] b, logic [15:0] c);
        t_in_item tri_in;
        int       gap;
        tri_in = '{side_a: a, side_b: b, side_c: c};
        gap    = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 11));
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= tri_in;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        expected_angles.push_back(predict_angles(tri_in));
        if (predict_angles(tri_in).invalid) n_invalid++;
        n_sent++;
    endtask

    // Sink side: random stalls per beat, or a long hold-off on request.
    initial begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_sink) begin
                out_ch.ready <= 1'b0;
                @(posedge i_clk);
            end else begin
                stall = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 11));
                if (stall > 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
                out_ch.ready <= 1'b1;
                @(posedge i_clk);
                while (!out_ch.valid) @(posedge i_clk);
            end
        end
    end

    // Result checker: every accepted beat against the oldest expectation.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_angles.size() == 0) begin
                $display("Result beat with no triangle outstanding");
                n_errors++;
            end else begin
                want = expected_angles.pop_front();
                if (out_ch.data.angle_a !== want.angle_a)
                    report_mismatch("angle_a", int'(out_ch.data.angle_a), int'(want.angle_a));
                if (out_ch.data.angle_b !== want.angle_b)
                    report_mismatch("angle_b", int'(out_ch.data.angle_b), int'(want.angle_b));
                if (out_ch.data.angle_c !== want.angle_c)
                    report_mismatch("angle_c", int'(out_ch.data.angle_c), int'(want.angle_c));
                if (out_ch.data.invalid !== want.invalid)
                    report_mismatch("invalid", int'(out_ch.data.invalid), int'(want.invalid));
            end
            n_checked++;
        end
    end

    // Watchdog on cycles with no beat on either side.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT && !timed_out) begin
            timed_out <= 1'b1;
            $display("Watchdog expired with %0d results outstanding", expected_angles.size());
            $display("FAILURE");
            $finish;
        end
    end

    task automatic test_extremes();
        send_triangle(16'd0, 16'd5, 16'd5);
        send_triangle(16'd5, 16'd0, 16'd5);
        send_triangle(16'd5, 16'd5, 16'd0);
        send_triangle(16'd0, 16'd0, 16'd0);
        send_triangle(16'd1, 16'd1, 16'd1);
        send_triangle(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_triangle(16'hFFFF, 16'd1, 16'hFFFF);
        send_triangle(16'd1, 16'hFFFF, 16'hFFFF);
        send_triangle(16'hFFFF, 16'hFFFF, 16'd1);
        send_triangle(16'h5555, 16'hAAAA, 16'hAAAA);
    endtask

    task automatic test_special_shapes();
        // Right, degenerate (ratio exactly at one end) and impossible triangles.
        send_triangle(16'd3, 16'd4, 16'd5);
        send_triangle(16'd5, 16'd12, 16'd13);
        send_triangle(16'd2, 16'd1, 16'd1);
        send_triangle(16'd1, 16'd2, 16'd1);
        send_triangle(16'hFFFE, 16'h7FFF, 16'h7FFF);
        send_triangle(16'd3, 16'd1, 16'd1);
        send_triangle(16'hFFFF, 16'd1, 16'd2);
        send_triangle(16'd1, 16'd1, 16'hFFFF);
        send_triangle(16'd2, 16'd1, 16'd2);
        send_triangle(16'd1000, 16'd999, 16'd1);
    endtask

    // Long receiver hold-off while triangles keep coming, so the block back-pressures.
    task automatic test_backpressure();
        hold_sink = 1'b1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                hold_sink = 1'b0;
            end
            repeat (90) send_triangle(16'($urandom_range(1, 200)), 16'($urandom_range(1, 200)),
                                      16'($urandom_range(1, 200)));
        join
    endtask

    task automatic test_random_triangles(int count);
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
        int          sel;
        for (int k = 0; k < count; k++) begin
            a   = 16'($urandom);
            b   = 16'($urandom);
            sel = int'($urandom_range(0, 9));
            if (sel < 7) begin
                // Mostly proper triangles: c strictly between |a-b| and a+b where it fits.
                if (a == 0) a = 1;
                if (b == 0) b = 1;
                c = 16'($urandom_range((a > b ? a - b : b - a) + 1,
                        (32'(a) + b - 1 > 65535) ? 65535 : a + b - 1));
                if (sel == 0) begin
                    a = a >> $urandom_range(0, 15);
                    b = 16'(a + $urandom_range(0, 3));
                    c = a;
                    if (a == 0) a = 1;
                end
            end else if (sel == 7) begin
                c = 16'(32'(a) + b);
            end else begin
                c = 16'($urandom);
            end
            send_triangle(a, b, c);
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.data    = '0;
        n_errors      = 0;
        n_sent        = 0;
        n_checked     = 0;
        n_invalid     = 0;
        idle_cycles   = 0;
        hold_sink     = 1'b0;
        timed_out     = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_special_shapes();
        test_backpressure();
        test_random_triangles(600);
        in_ch.valid <= 1'b0;

        while (expected_angles.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);

        $display("Sent %0d triangles (%0d invalid) and checked %0d result beats,",
                 n_sent, n_invalid, n_checked);
        $display("including edge sides, degenerate shapes and a long receiver stall.");
        if (n_errors == 0 && expected_angles.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
